// ===== rtl/core/ipkm_pkg.sv =====
// Package for the identifier prefix key matcher: table sizes, item codes,
// word structs and the prefix key function. No dependencies.
package ipkm_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int TEXT_W      = 64;
    localparam int MATCH_W     = 13;
    localparam int CHARS       = 8;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TEXT_W-1:0] key_text;
    } in_word_t;

    typedef struct packed {
        logic [MATCH_W-1:0] match_index;
        logic               table_full;
    } out_word_t;

    // '0'..'9' -> 1..10, 'A'..'F' -> 11..16, anything else -> 0
    function automatic logic [4:0] char_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30) + 5'd1;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41) + 5'd11;
        end
        return v;
    endfunction

    // key = key * 16 + value per character, first character in the top byte.
    // Values are 5 bits on a 4-bit pitch: even and odd characters each form a
    // field set with no overlap, so the whole key is a single add of the two.
    function automatic logic [KEY_W-1:0] prefix_key(input logic [TEXT_W-1:0] text);
        logic [KEY_W-1:0] even_part;
        logic [KEY_W-1:0] odd_part;
        logic [4:0]       v;
        even_part = '0;
        odd_part  = '0;
        for (int p = 0; p < CHARS; p++) begin
            v = char_value(text[TEXT_W-1-8*p -: 8]);
            if ((p & 1) == 0) begin
                even_part = even_part | (KEY_W'(v) << (4 * (CHARS - 1 - p)));
            end else begin
                odd_part = odd_part | (KEY_W'(v) << (4 * (CHARS - 1 - p)));
            end
        end
        return even_part + odd_part;
    endfunction

endpackage

// ===== rtl/core/ipkm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ipkm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/id_prefix_key_match.sv =====
// Identifier prefix key matcher top level: key table in ipkm_ram, scan FSM.
// Depends on ipkm_pkg and ipkm_ram.
//
//  channel  | ports                    | word        | direction
//  ---------+--------------------------+-------------+----------
//  input    | s_valid s_ready s_word   | in_word_t   | in
//  result   | m_valid m_ready m_word   | out_word_t  | out
//
// Clear, append and unused kinds pass from acceptance through ST_FIN into the
// result register. A query scans from the first stored key up to the first
// match, or through all entry_count keys when nothing matches: one stored key
// is read and compared per cycle from the key RAM's single read port.
// Reset (aresetn low, synchronous) empties the table; no clearing pass.
// A finished result waits in the output register; the next word is taken
// while it waits, and only the hand-off into that register stalls.
module id_prefix_key_match
    import ipkm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    out_word_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_word_reg, m_word_next;

    logic                accept;
    logic                table_is_full;
    logic [KEY_W-1:0]    in_key;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]    idx_plus1;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign in_key        = prefix_key(s_word.key_text);
    assign table_is_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign idx_plus1     = {1'b0, idx_reg} + CNT_W'(1);

    // write on append when the table is not full, read address follows the scan index
    assign ram_we    = accept && (s_word.kind == KIND_APPEND) && !table_is_full;
    assign ram_raddr = (state_reg == ST_SCAN) ? idx_plus1[ADDR_W-1:0] : '0;

    ipkm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_key),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control and scan
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next   = in_key;
                    idx_next   = '0;
                    res_next   = '0;
                    state_next = ST_FIN;
                    unique case (kind_t'(s_word.kind))
                        KIND_CLEAR: count_next = '0;
                        KIND_APPEND: begin
                            if (table_is_full) begin
                                res_next.table_full = 1'b1;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_QUERY: begin
                            if (count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (ram_rdata == key_reg) begin
                    res_next.match_index = MATCH_W'(idx_plus1);
                    state_next           = ST_FIN;
                end else if (idx_plus1 == count_reg) begin
                    state_next = ST_FIN;
                end else begin
                    idx_next = idx_plus1[ADDR_W-1:0];
                end
            end
            ST_FIN: begin
                // hand off once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== rtl/core/ipkm_checker.sv =====
// Port-level checks for id_prefix_key_match, bound to the top level.
// Depends on ipkm_pkg.
module ipkm_checker
    import ipkm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_word,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // one word in flight: ready drops after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

    // a dropped append never carries a position
    a_full_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.table_full |-> m_word.match_index == '0)
        else $error("table_full with nonzero match_index");

    // position never beyond the table
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.match_index <= MATCH_W'(TABLE_DEPTH))
        else $error("match_index beyond table depth");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind id_prefix_key_match ipkm_checker u_ipkm_checker (.*);
